[sv/assert_macros.svh]
// Assertion helpers used by the ring's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, ignored while rst is high.
`define TETR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked on every rising clk edge, reset included.
`define TETR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[sv/tetr_pkg.sv]
`default_nettype none

package tetr_pkg;

  localparam int RING_SLOTS = 32;
  // One slot of the ring stays free, so the chain holds one entry less.
  localparam int CELLS = RING_SLOTS - 1;
  localparam int CNT_W = $clog2(RING_SLOTS);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [31:0] COARSE_LIMIT_US = 32'd1000000;
  localparam logic [25:0] WRAP_BIAS       = 26'd32768;
  localparam logic [13:0] FRAC_STEP       = 14'd625;
  localparam logic [7:0]  DROP_MAX        = 8'd255;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  event_code;
    logic [15:0] cycle_number;
    logic [31:0] coarse_us;
    logic [31:0] age_us;
    logic [15:0] fine_ticks;
  } cmd_t;

  typedef struct packed {
    logic        ring_empty;
    logic [7:0]  out_event;
    logic [15:0] out_cycle;
    logic [31:0] out_stamp_us;
    logic [15:0] out_fine;
    logic        gap_valid;
    logic        gap_precise;
    logic [31:0] gap_whole_us;
    logic [13:0] gap_frac;
    logic [7:0]  dropped_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  event_code;
    logic [15:0] cycle_number;
    logic [31:0] stamp_us;
    logic [15:0] fine;
  } entry_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] fill;
  } cell_ctrl_t;

  // A pop captured at accept time, finished by the gap unit.
  typedef struct packed {
    logic        empty;
    entry_t      entry;
    logic        have_prev;
    logic [31:0] coarse;
    logic [15:0] fdelta;
    logic [7:0]  drops;
  } pop_t;

endpackage

`default_nettype wire

[sv/tetr_if.sv]
`default_nettype none

interface tetr_cmd_if;
  logic          valid;
  logic          ready;
  tetr_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tetr_rsp_if;
  logic          valid;
  logic          ready;
  tetr_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/tetr_cell.sv]
`default_nettype none

module tetr_cell (
  input  wire logic                      clk,
  input  wire tetr_pkg::cell_ctrl_t      ctrl,
  input  wire logic [tetr_pkg::CNT_W-1:0] idx,
  input  wire tetr_pkg::entry_t          new_entry,
  input  wire tetr_pkg::entry_t          upper,
  output tetr_pkg::entry_t               q
);

  // A push lands in the first free cell; a pop moves every cell one step
  // toward the head.
  always_ff @(posedge clk) begin
    if (ctrl.push && ctrl.fill == idx) begin
      q <= new_entry;
    end else if (ctrl.pop) begin
      q <= upper;
    end
  end

endmodule

`default_nettype wire

[sv/tetr_gap.sv]
`default_nettype none

module tetr_gap (
  input  wire tetr_pkg::pop_t pop,
  output tetr_pkg::rsp_t      rsp
);

  logic signed [25:0] biased;
  logic [7:0]         wraps;
  logic [23:0]        ticks;

  // Unwrap the fine delta against the coarse delta, 16 ticks per us.
  assign biased = $signed({2'b00, pop.coarse[19:0], 4'b0000})
                - $signed({10'b0, pop.fdelta})
                + $signed(tetr_pkg::WRAP_BIAS);
  assign wraps  = (biased <= 26'sd0) ? 8'd0 : biased[23:16];
  assign ticks  = {wraps, pop.fdelta};

  always_comb begin
    rsp = '0;
    if (pop.empty) begin
      rsp.ring_empty    = 1'b1;
      rsp.dropped_count = pop.drops;
    end else begin
      rsp.out_event    = pop.entry.event_code;
      rsp.out_cycle    = pop.entry.cycle_number;
      rsp.out_stamp_us = pop.entry.stamp_us;
      rsp.out_fine     = pop.entry.fine;
      if (pop.have_prev) begin
        rsp.gap_valid = 1'b1;
        if (pop.coarse >= tetr_pkg::COARSE_LIMIT_US) begin
          rsp.gap_whole_us = pop.coarse;
        end else begin
          rsp.gap_precise  = 1'b1;
          rsp.gap_whole_us = {12'b0, ticks[23:4]};
          rsp.gap_frac     = {10'b0, ticks[3:0]} * tetr_pkg::FRAC_STEP;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/timestamped_event_trace_ring.sv]
// Event trace ring: a chain of entry cells that shifts toward the head on pop.
// Throughput: one item per cycle while rsp is not stalled; push, pop and clear
// all take effect at accept. A pop result passes the capture register, then
// the gap unwrap and the output register.
// Reset (rst, synchronous): ring empty, drop count zero, no previous entry,
// logging disabled. Cell contents are not cleared.
`default_nettype none

`include "assert_macros.svh"

module timestamped_event_trace_ring (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  tetr_cmd_if.sink        cmd,
  tetr_rsp_if.source      rsp
);

  localparam logic [tetr_pkg::CNT_W-1:0] FULL_FILL = tetr_pkg::CNT_W'(tetr_pkg::CELLS);
  localparam logic [tetr_pkg::CNT_W-1:0] ONE_FILL  = tetr_pkg::CNT_W'(1);

  logic                        log_en;
  logic [tetr_pkg::CNT_W-1:0]  fill;
  logic [7:0]                  lost;
  logic [31:0]                 prev_stamp;
  logic [15:0]                 prev_fine;
  logic                        have_prev;

  tetr_pkg::entry_t            cells [tetr_pkg::CELLS];
  tetr_pkg::entry_t            new_entry;
  tetr_pkg::cell_ctrl_t        ctrl;

  tetr_pkg::pop_t              s1;
  logic                        s1_valid;
  tetr_pkg::rsp_t              gap_out;
  tetr_pkg::rsp_t              out_q;
  logic                        out_valid;

  logic cmd_acc, is_push, is_pop, is_clear, full, do_store, pop_hit, s1_move;

  assign cmd_acc  = cmd.valid && cmd.ready;
  assign is_push  = cmd_acc && cmd.data.operation == tetr_pkg::OP_PUSH && log_en;
  assign is_pop   = cmd_acc && cmd.data.operation == tetr_pkg::OP_POP;
  assign is_clear = cmd_acc && cmd.data.operation == tetr_pkg::OP_CLEAR;
  assign full     = fill == FULL_FILL;
  assign do_store = is_push && !full;
  assign pop_hit  = is_pop && fill != '0;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_move;

  assign new_entry.event_code   = cmd.data.event_code;
  assign new_entry.cycle_number = cmd.data.cycle_number;
  assign new_entry.stamp_us     = cmd.data.coarse_us - cmd.data.age_us;
  assign new_entry.fine         = cmd.data.fine_ticks;

  assign ctrl.push = do_store;
  assign ctrl.pop  = pop_hit;
  assign ctrl.fill = fill;

  for (genvar i = 0; i < tetr_pkg::CELLS; i++) begin : g_cell
    tetr_pkg::entry_t upper;
    if (i == tetr_pkg::CELLS - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    tetr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .idx       (tetr_pkg::CNT_W'(i)),
      .new_entry (new_entry),
      .upper     (upper),
      .q         (cells[i])
    );
  end

  tetr_gap u_gap (
    .pop (s1),
    .rsp (gap_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      log_en     <= 1'b0;
      fill       <= '0;
      lost       <= '0;
      prev_stamp <= '0;
      prev_fine  <= '0;
      have_prev  <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        log_en <= cfg_wr_data;
      end

      if (is_clear) begin
        fill      <= '0;
        lost      <= '0;
        have_prev <= 1'b0;
      end else if (do_store) begin
        fill <= fill + ONE_FILL;
      end else if (is_push && full) begin
        if (lost != tetr_pkg::DROP_MAX) begin
          lost <= lost + 8'd1;
        end
      end else if (pop_hit) begin
        fill       <= fill - ONE_FILL;
        prev_stamp <= cells[0].stamp_us;
        prev_fine  <= cells[0].fine;
        have_prev  <= 1'b1;
      end else if (is_pop) begin
        lost <= '0;
      end

      if (is_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_pop) begin
      s1.empty     <= fill == '0;
      s1.entry     <= cells[0];
      s1.have_prev <= have_prev;
      s1.coarse    <= cells[0].stamp_us - prev_stamp;
      s1.fdelta    <= cells[0].fine - prev_fine;
      s1.drops     <= lost;
    end
    if (s1_move) begin
      out_q <= gap_out;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  `TETR_ASSERT(a_fill_bound, fill <= FULL_FILL)
  `TETR_ASSERT_ALWAYS(a_reset_idle, rst |=> (fill == '0 && !s1_valid && !out_valid))
  `TETR_ASSERT(a_clear_empties, is_clear |=> (fill == '0 && lost == '0 && !have_prev))
  `TETR_ASSERT(a_stall_blocks_input, (s1_valid && out_valid && !rsp.ready) |-> !cmd.ready)

endmodule

`default_nettype wire

[bench/tb_timestamped_event_trace_ring.sv]
`timescale 1ns / 1ps

module tb_timestamped_event_trace_ring;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RING_DEPTH = tetr_pkg::RING_SLOTS - 1;
  localparam int FINE_PER_US = 16;
  localparam int FRAC_UNIT = 625;
  localparam logic [31:0] ONE_SECOND_US = 32'd1000000;
  localparam int TOTAL_ITEMS = 950;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {SEQ_STREAM, SEQ_FLOOD, SEQ_CLEAR, SEQ_NOISE} seq_kind_t;

  typedef struct {
    bit             is_cfg;
    bit             cfg_val;
    tetr_pkg::cmd_t c;
    bit             pinned;
    tetr_pkg::rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  tetr_cmd_if cmd();
  tetr_rsp_if rsp();

  timestamped_event_trace_ring DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .rsp        (rsp)
  );

  // predictor state
  tetr_pkg::entry_t ring_model[$];
  logic [7:0]       drop_tally;
  bit               prev_known;
  logic [31:0]      prev_stamp;
  logic [15:0]      prev_fine;
  bit               log_en;

  tetr_pkg::rsp_t   due_pops[$];
  plan_row_t        plan[$];
  logic [63:0]      now_ticks;
  int               tx_gap_pct;
  int               rx_stall_pct;
  int               counted_items;
  int               mismatch_count;
  int               cycle_count;

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  task automatic check_pop(tetr_pkg::rsp_t got, tetr_pkg::rsp_t want);
    cmp_field("ring_empty", 32'(got.ring_empty), 32'(want.ring_empty));
    cmp_field("out_event", 32'(got.out_event), 32'(want.out_event));
    cmp_field("out_cycle", 32'(got.out_cycle), 32'(want.out_cycle));
    cmp_field("out_stamp_us", got.out_stamp_us, want.out_stamp_us);
    cmp_field("out_fine", 32'(got.out_fine), 32'(want.out_fine));
    cmp_field("gap_valid", 32'(got.gap_valid), 32'(want.gap_valid));
    cmp_field("gap_precise", 32'(got.gap_precise), 32'(want.gap_precise));
    cmp_field("gap_whole_us", got.gap_whole_us, want.gap_whole_us);
    cmp_field("gap_frac", 32'(got.gap_frac), 32'(want.gap_frac));
    cmp_field("dropped_count", 32'(got.dropped_count), 32'(want.dropped_count));
  endtask

  // Advances the predicted ring by one item; returns 1 when a pop result is due.
  function automatic bit trace_step(input tetr_pkg::cmd_t c, output tetr_pkg::rsp_t r);
    tetr_pkg::entry_t e;
    logic [31:0]      coarse;
    logic [15:0]      fdelta;
    logic [31:0]      wraps;
    logic [31:0]      ticks;
    int               offs;
    int               biased;
    r = '0;
    case (c.operation)
      tetr_pkg::OP_PUSH: begin
        if (log_en) begin
          if (ring_model.size() == RING_DEPTH) begin
            if (drop_tally != 8'd255) drop_tally++;
          end else begin
            e.event_code   = c.event_code;
            e.cycle_number = c.cycle_number;
            e.stamp_us     = c.coarse_us - c.age_us;
            e.fine         = c.fine_ticks;
            ring_model.push_back(e);
          end
        end
        return 1'b0;
      end
      tetr_pkg::OP_CLEAR: begin
        ring_model.delete();
        drop_tally = '0;
        prev_known = 1'b0;
        return 1'b0;
      end
      tetr_pkg::OP_POP: begin
        if (ring_model.size() == 0) begin
          r.ring_empty    = 1'b1;
          r.dropped_count = drop_tally;
          drop_tally      = '0;
          return 1'b1;
        end
        e = ring_model.pop_front();
        r.out_event    = e.event_code;
        r.out_cycle    = e.cycle_number;
        r.out_stamp_us = e.stamp_us;
        r.out_fine     = e.fine;
        if (prev_known) begin
          coarse      = e.stamp_us - prev_stamp;
          fdelta      = e.fine - prev_fine;
          r.gap_valid = 1'b1;
          if (coarse >= ONE_SECOND_US) begin
            r.gap_whole_us = coarse;
          end else begin
            // pick the number of 16-bit fine wraps nearest to the coarse delta
            offs   = int'(coarse) * FINE_PER_US - int'({16'd0, fdelta});
            biased = offs + 32768;
            wraps  = (biased <= 0) ? 32'd0 : 32'(biased >>> 16);
            ticks  = (wraps << 16) + {16'd0, fdelta};
            r.gap_precise  = 1'b1;
            r.gap_whole_us = ticks / FINE_PER_US;
            r.gap_frac     = 14'((ticks % FINE_PER_US) * FRAC_UNIT);
          end
        end
        prev_stamp = e.stamp_us;
        prev_fine  = e.fine;
        prev_known = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic tetr_pkg::rsp_t mk_rsp(bit empty, logic [7:0] ev, logic [15:0] cyc,
                                  logic [31:0] stamp, logic [15:0] fine, bit gv, bit gp,
                                  logic [31:0] whole, logic [13:0] frac, logic [7:0] drops);
    tetr_pkg::rsp_t r;
    r.ring_empty    = empty;
    r.out_event     = ev;
    r.out_cycle     = cyc;
    r.out_stamp_us  = stamp;
    r.out_fine      = fine;
    r.gap_valid     = gv;
    r.gap_precise   = gp;
    r.gap_whole_us  = whole;
    r.gap_frac      = frac;
    r.dropped_count = drops;
    return r;
  endfunction

  function automatic plan_row_t cmd_row(logic [1:0] op, logic [7:0] ev, logic [15:0] cyc,
                                        logic [31:0] coarse, logic [31:0] age,
                                        logic [15:0] fine);
    plan_row_t row;
    row.is_cfg         = 1'b0;
    row.cfg_val        = 1'b0;
    row.c.operation    = op;
    row.c.event_code   = ev;
    row.c.cycle_number = cyc;
    row.c.coarse_us    = coarse;
    row.c.age_us       = age;
    row.c.fine_ticks   = fine;
    row.pinned         = 1'b0;
    row.want           = '0;
    return row;
  endfunction

  function automatic plan_row_t pop_row(bit pin, tetr_pkg::rsp_t want);
    plan_row_t row;
    row        = cmd_row(tetr_pkg::OP_POP, '0, '0, '0, '0, '0);
    row.pinned = pin;
    row.want   = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(bit v);
    plan_row_t row;
    row         = cmd_row(tetr_pkg::OP_PUSH, '0, '0, '0, '0, '0);
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  // Pushes follow a running tick clock so coarse and fine agree; noisy ones do not.
  function automatic tetr_pkg::cmd_t make_cmd(logic [1:0] op, bit noisy);
    tetr_pkg::cmd_t c;
    logic [63:0]    stride;
    c.operation    = op;
    c.event_code   = 8'($urandom);
    c.cycle_number = 16'($urandom);
    c.coarse_us    = $urandom;
    c.age_us       = $urandom;
    c.fine_ticks   = 16'($urandom);
    if (op == tetr_pkg::OP_PUSH && !noisy) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stride = 64'($urandom_range(0, 64));
        4, 5:       stride = 64'($urandom_range(0, 16 * 2000));
        6:          stride = 64'($urandom_range(0, 16 * 70000));
        7:          stride = 64'(16 * 1000000 - 40 + $urandom_range(0, 80));
        8:          stride = 64'($urandom_range(0, 16 * 1000000));
        default:    stride = {24'd0, 8'($urandom), $urandom};
      endcase
      now_ticks    += stride;
      c.coarse_us  = now_ticks[35:4];
      c.fine_ticks = now_ticks[15:0];
      c.age_us     = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 3)) : 32'd0;
    end
    return c;
  endfunction

  function automatic bit pick_noisy();
    return ($urandom_range(0, 15) == 0);
  endfunction

  task automatic send(tetr_pkg::cmd_t c, bit pinned, tetr_pkg::rsp_t want);
    tetr_pkg::rsp_t predicted;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      cmd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_gap_pct);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= c;
    do @(posedge clk); while (!cmd.ready);
    counted_items++;
    if (trace_step(c, predicted)) due_pops.push_back(pinned ? want : predicted);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (due_pops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_logging(bit v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    log_en = v;
  endtask

  // Fill to capacity, lose `extra` pushes, then empty it and read the drop count.
  task automatic run_flood(int extra);
    while (ring_model.size() < RING_DEPTH) begin
      send(make_cmd(tetr_pkg::OP_PUSH, pick_noisy()), 1'b0, '0);
    end
    repeat (extra) send(make_cmd(tetr_pkg::OP_PUSH, pick_noisy()), 1'b0, '0);
    while (ring_model.size() > 0) send(make_cmd(tetr_pkg::OP_POP, 1'b0), 1'b0, '0);
    send(make_cmd(tetr_pkg::OP_POP, 1'b0), 1'b0, '0);
  endtask

  task automatic run_sequence(seq_kind_t kind);
    case (kind)
      SEQ_FLOOD: run_flood($urandom_range(1, 20));
      SEQ_CLEAR: begin
        repeat ($urandom_range(0, 8)) begin
          send(make_cmd(tetr_pkg::OP_PUSH, pick_noisy()), 1'b0, '0);
        end
        send(make_cmd(tetr_pkg::OP_CLEAR, 1'b0), 1'b0, '0);
        repeat ($urandom_range(1, 6)) begin
          send(make_cmd(($urandom_range(0, 1) == 0) ? tetr_pkg::OP_PUSH : tetr_pkg::OP_POP,
                        1'b0), 1'b0, '0);
        end
      end
      SEQ_NOISE: begin
        repeat ($urandom_range(4, 20)) send(make_cmd(2'($urandom_range(0, 3)), 1'b1), 1'b0, '0);
      end
      default: begin
        repeat ($urandom_range(4, 40)) begin
          send(make_cmd(($urandom_range(0, 99) < 55) ? tetr_pkg::OP_PUSH : tetr_pkg::OP_POP,
                        pick_noisy()), 1'b0, '0);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_pops.size() == 0) report_mismatch("pop result with none outstanding");
      else check_pop(rsp.data, due_pops.pop_front());
    end
  end

  initial begin
    int        ph;
    int        target;
    int        phase_tx;
    int        r;
    seq_kind_t kind;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    cmd.valid      = 1'b0;
    cmd.data       = '0;
    rsp.ready      = 1'b0;
    drop_tally     = '0;
    prev_known     = 1'b0;
    prev_stamp     = '0;
    prev_fine      = '0;
    log_en         = 1'b0;
    now_ticks      = {32'd0, $urandom};
    tx_gap_pct     = 0;
    rx_stall_pct   = 0;
    counted_items  = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    // logging starts disabled
    plan.push_back(pop_row(1'b1, mk_rsp(1'b1, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'hA5, 16'h5A5A, 32'd77, 32'd0, 16'h0123));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b1, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));
    plan.push_back(cfg_row(1'b1));
    // first entry has nothing to measure against
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
                           16'hFFFF));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                        1'b0, 1'b0, 32'd0, 14'd0, 8'd0)));
    // exactly one second across the stamp wrap: coarse only
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h00, 16'h0000, 32'd999999, 32'd0, 16'h0000));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b0, 8'd0, 16'd0, 32'd999999, 16'd0, 1'b1, 1'b0,
                                        32'd1000000, 14'd0, 8'd0)));
    // same stamp, fine counter one behind: unwrap clamps to zero wraps
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h5A, 16'h1234, 32'd1999999, 32'd1000000,
                           16'hFFFF));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b0, 8'h5A, 16'h1234, 32'd999999, 16'hFFFF,
                                        1'b1, 1'b1, 32'd4095, 14'd9375, 8'd0)));
    // largest delta that still takes the fine path
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h3C, 16'd8000, 32'd1999998, 32'd0, 16'h1234));
    plan.push_back(pop_row(1'b0, '0));
    plan.push_back(cmd_row(OP_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b1, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h11, 16'd1, 32'd100, 32'd0, 16'h0640));
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h22, 16'd2, 32'd101, 32'd0, 16'h0650));
    plan.push_back(cmd_row(tetr_pkg::OP_CLEAR, 8'h00, 16'd0, 32'd0, 32'd0, 16'h0000));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b1, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));
    // clear forgot the previous entry
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h33, 16'd3, 32'd0, 32'd0, 16'h0000));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b0, 8'h33, 16'd3, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h44, 16'd4, 32'd0, 32'd0, 16'h0008));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b0, 8'h44, 16'd4, 32'd0, 16'h0008, 1'b1, 1'b1,
                                        32'd0, 14'd5000, 8'd0)));
    plan.push_back(cfg_row(1'b0));
    plan.push_back(cmd_row(tetr_pkg::OP_PUSH, 8'h66, 16'd6, 32'd5, 32'd0, 16'h0050));
    plan.push_back(pop_row(1'b1, mk_rsp(1'b1, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                        32'd0, 14'd0, 8'd0)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_logging(plan[i].cfg_val);
      else send(plan[i].c, plan[i].pinned, plan[i].want);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin phase_tx = 0;  rx_stall_pct = 0;  end
        1:       begin phase_tx = 48; rx_stall_pct = 0;  end
        2:       begin phase_tx = 0;  rx_stall_pct = 48; end
        default: begin phase_tx = 19; rx_stall_pct = 19; end
      endcase
      tx_gap_pct = 0;
      set_logging(1'b1);
      // drive the drop counter past saturation once
      if (ph == 0) run_flood(300);
      target = (ph + 1) * TOTAL_ITEMS / 4;
      while (counted_items < target) begin
        if ($urandom_range(0, 11) == 0) begin
          set_logging($urandom_range(0, 2) != 0);
        end
        tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : phase_tx;
        r = $urandom_range(0, 9);
        if (r <= 5) kind = SEQ_STREAM;
        else if (r <= 7) kind = log_en ? SEQ_FLOOD : SEQ_STREAM;
        else if (r == 8) kind = SEQ_CLEAR;
        else kind = SEQ_NOISE;
        run_sequence(kind);
      end
    end

    drain();
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[timestamped_event_trace_ring.f]
+incdir+sv
sv/tetr_pkg.sv
sv/tetr_if.sv
sv/tetr_cell.sv
sv/tetr_gap.sv
sv/timestamped_event_trace_ring.sv
bench/tb_timestamped_event_trace_ring.sv
